FILE: design/serial_commanded_hbridge_pwm_assert.svh
// Assertion macros used by the motor controller RTL.
`ifndef SERIAL_COMMANDED_HBRIDGE_PWM_ASSERT_SVH
`define SERIAL_COMMANDED_HBRIDGE_PWM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHBP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SHBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shbp assertion failed");

`endif

FILE: design/shbp_pkg.sv
// Types and constants of the serial commanded H-bridge PWM controller.
package shbp_pkg;

   // Command and digit characters.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_L     = 8'h6c;
   localparam logic [7:0] CHAR_P     = 8'h70;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_S     = 8'h73;

   // Largest duty cycle in percent.
   localparam logic [6:0] DUTY_MAX   = 7'd100;

   // Transaction kinds on the request channel.
   localparam logic       OP_TICK    = 1'b0;
   localparam logic       OP_BYTE    = 1'b1;

   // Message codes reported with each result.
   typedef enum logic [3:0] {
      MSG_NONE     = 4'd0,
      MSG_EXIT     = 4'd1,
      MSG_AUTO     = 4'd2,
      MSG_RIGHTSET = 4'd3,
      MSG_LEFTSET  = 4'd4,
      MSG_SELECTED = 4'd5,
      MSG_LEFT     = 4'd6,
      MSG_RIGHT    = 4'd7,
      MSG_STOP     = 4'd8,
      MSG_COAST    = 4'd9,
      MSG_SETUP    = 4'd10
   } msg_type;

   // Bridge pin levels.
   typedef struct packed {
      logic drive_left;
      logic drive_right;
      logic bridge_enable;
   } pins_type;

   // Result transaction, last field in the lowest bits.
   typedef struct packed {
      logic [6:0] selected_duty;
      msg_type    message_code;
      logic [7:0] echo_byte;
      logic       echo_valid;
      pins_type   pins;
   } rsp_type;

endpackage

FILE: design/serial_commanded_hbridge_pwm.sv
// Top level of the serial commanded H-bridge PWM controller.
//
// Usage:
//   The request channel carries one event per transaction: req_tuser = 0 is a
//   timer tick, req_tuser = 1 is a received serial byte in req_tdata.
//   The response channel returns exactly one result per request, holding the
//   bridge pin levels after the event, the setup echo and a message code.
//   A request is accepted into the input register; the output register
//   then loads the decode and state update once it is empty or its result
//   is taken. Throughput is one transaction per clock while the receiver
//   takes each response, set by the single pass of decode logic between
//   the two registers.
//   When the receiver stalls, the output register holds its result and the
//   input register still takes one more request; after that req_tready drops
//   until the response is taken.
//   Reset clears the valid flags of both registers, the PWM counter, duty,
//   mode, direction, setup flag and digit slots, and turns the bridge off.
`include "serial_commanded_hbridge_pwm_assert.svh"

module serial_commanded_hbridge_pwm #(
   parameter int PWM_TOP = 100
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] opcode
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [0] bridge_enable, [1] drive_right,
                                    // [2] drive_left, [3] echo_valid,
                                    // [11:4] echo_byte, [15:12] message_code,
                                    // [22:16] selected_duty, [23] zero
);
   import shbp_pkg::*;

   localparam int CountWidth = $clog2(PWM_TOP + 1);
   localparam int CmpWidth   = (CountWidth > 7) ? CountWidth : 7;
   localparam logic [CountWidth-1:0] CountTop = CountWidth'(PWM_TOP);

   // Input register.
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // Output register.
   logic       out_valid_ff;
   rsp_type    rsp_ff, rsp_in;

   // Controller state.
   logic [CountWidth-1:0] pwm_count_ff, pwm_count_in;
   logic [6:0]            duty_ff, duty_in;
   logic                  auto_ff, auto_in;
   logic                  reverse_ff, reverse_in;
   logic                  setup_ff, setup_in;
   logic [7:0]            slot0_ff, slot0_in;
   logic [7:0]            slot1_ff, slot1_in;
   pins_type              pins_ff, pins_in;

   logic advance;

   // Duty entry arithmetic.
   logic signed [15:0] digit0, digit1, digit2, duty_sum;
   logic [6:0]         duty_clamped;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

   // Weighted decimal value of the two stored slots and the incoming byte.
   always_comb begin
      digit0   = $signed({8'd0, slot0_ff}) - 16'sd48;
      digit1   = $signed({8'd0, slot1_ff}) - 16'sd48;
      digit2   = $signed({8'd0, in_byte_ff}) - 16'sd48;
      duty_sum = (digit0 * 16'sd100) + (digit1 * 16'sd10) + digit2;
      if (duty_sum < 16'sd0) begin
         duty_clamped = 7'd0;
      end else if (duty_sum > 16'sd100) begin
         duty_clamped = DUTY_MAX;
      end else begin
         duty_clamped = duty_sum[6:0];
      end
   end

   // Event decode and next state.
   always_comb begin
      pwm_count_in = pwm_count_ff;
      duty_in      = duty_ff;
      auto_in      = auto_ff;
      reverse_in   = reverse_ff;
      setup_in     = setup_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      pins_in      = pins_ff;
      rsp_in       = '0;

      if (in_op_ff == OP_TICK) begin
         // Timer tick: PWM compare in auto mode, then count.
         if (auto_ff) begin
            if (CmpWidth'(pwm_count_ff) < CmpWidth'(duty_ff)) begin
               pins_in.bridge_enable = 1'b1;
               pins_in.drive_left    = reverse_ff;
               pins_in.drive_right   = !reverse_ff;
            end else begin
               pins_in = '0;
            end
         end
         if (pwm_count_ff >= CountTop) begin
            pwm_count_in = '0;
         end else begin
            pwm_count_in = pwm_count_ff + CountWidth'(1);
         end
      end else if (setup_ff) begin
         // Setup mode: echo everything, commands or digit collection.
         rsp_in.echo_valid = 1'b1;
         rsp_in.echo_byte  = in_byte_ff;
         if (in_byte_ff == CHAR_C) begin
            rsp_in.message_code = MSG_EXIT;
            setup_in = 1'b0;
         end else if (in_byte_ff == CHAR_A) begin
            rsp_in.message_code = MSG_AUTO;
            auto_in = 1'b1;
         end else if (in_byte_ff == CHAR_R) begin
            rsp_in.message_code = MSG_RIGHTSET;
            reverse_in = 1'b0;
         end else if (in_byte_ff == CHAR_L) begin
            rsp_in.message_code = MSG_LEFTSET;
            reverse_in = 1'b1;
         end else if (slot0_ff == 8'd0) begin
            slot0_in = in_byte_ff;
         end else if (slot1_ff == 8'd0) begin
            slot1_in = in_byte_ff;
         end else begin
            duty_in  = duty_clamped;
            slot0_in = 8'd0;
            slot1_in = 8'd0;
            rsp_in.message_code  = MSG_SELECTED;
            rsp_in.selected_duty = duty_clamped;
         end
      end else begin
         // Manual commands.
         unique case (in_byte_ff)
            CHAR_L: begin
               rsp_in.message_code = MSG_LEFT;
               auto_in = 1'b0;
               pins_in = '{drive_left: 1'b1, drive_right: 1'b0, bridge_enable: 1'b1};
            end
            CHAR_R: begin
               rsp_in.message_code = MSG_RIGHT;
               auto_in = 1'b0;
               pins_in = '{drive_left: 1'b0, drive_right: 1'b1, bridge_enable: 1'b1};
            end
            CHAR_S: begin
               rsp_in.message_code = MSG_STOP;
               auto_in = 1'b0;
               pins_in = '{drive_left: 1'b0, drive_right: 1'b0, bridge_enable: 1'b1};
            end
            CHAR_P: begin
               rsp_in.message_code = MSG_COAST;
               auto_in = 1'b0;
               pins_in = '0;
            end
            CHAR_D: begin
               rsp_in.message_code = MSG_SETUP;
               setup_in = 1'b1;
            end
            default: begin
               rsp_in.message_code = MSG_NONE;
            end
         endcase
      end
      rsp_in.pins = pins_in;
   end

   // Input register load.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // Output register and state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pwm_count_ff <= '0;
         duty_ff      <= '0;
         auto_ff      <= 1'b0;
         reverse_ff   <= 1'b0;
         setup_ff     <= 1'b0;
         slot0_ff     <= '0;
         slot1_ff     <= '0;
         pins_ff      <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            pwm_count_ff <= pwm_count_in;
            duty_ff      <= duty_in;
            auto_ff      <= auto_in;
            reverse_ff   <= reverse_in;
            setup_ff     <= setup_in;
            slot0_ff     <= slot0_in;
            slot1_ff     <= slot1_in;
            pins_ff      <= pins_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Both bridge terminals are never driven high together.
   `SHBP_ASSERT_SAME(a_no_shoot_through, clock, reset, 1'b1,
      !(pins_ff.drive_left && pins_ff.drive_right))
   // The stored duty stays within 0..100 percent.
   `SHBP_ASSERT_SAME(a_duty_range, clock, reset, 1'b1, duty_ff <= DUTY_MAX)
   // A duty is reported only with the selection message.
   `SHBP_ASSERT_SAME(a_duty_with_msg, clock, reset,
      out_valid_ff && (rsp_ff.message_code != MSG_SELECTED), rsp_ff.selected_duty == 7'd0)
   // Echoed results only carry setup-mode messages.
   `SHBP_ASSERT_SAME(a_echo_msgs, clock, reset, out_valid_ff && rsp_ff.echo_valid,
      rsp_ff.message_code <= MSG_SELECTED)
   // Each processed event leaves a result in the output register.
   `SHBP_ASSERT_NEXT(a_advance_result, clock, reset, advance, out_valid_ff)

endmodule
